### src/assert_macros.svh
// Assertion macros shared by the circular queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CQS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CQS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### src/cqs_pkg.sv
// Shared types and constants of the circular queue with search.
package cqs_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned CAP_W         = 5;
   localparam int unsigned OP_W          = 2;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned SLOT_W        = 4;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic csr_write;
      logic capture;
      logic decode;
      logic remove_done;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   scan_done;
   } stat_type;

endpackage

### src/cqs_ifs.sv
// Valid/ready channel interfaces of the circular queue with search.
interface cqs_req_if;
   import cqs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

interface cqs_rsp_if;
   import cqs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] removed_value;
   logic [SLOT_W-1:0]         found_slot;
   modport source (output valid, output status, output removed_value, output found_slot,
                   input ready);
   modport sink (input valid, input status, input removed_value, input found_slot,
                 output ready);
endinterface

interface cqs_csr_if;
   import cqs_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/cqs_datapath.sv
// Datapath: slot memory, ring pointers, search pipeline and result register.
`include "assert_macros.svh"

module cqs_datapath #(
   parameter int unsigned DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cqs_pkg::cmd_type                  cmd,
   output cqs_pkg::stat_type                 stat,
   input  logic [cqs_pkg::OP_W-1:0]          req_operation,
   input  logic signed [cqs_pkg::VALUE_W-1:0] req_value,
   input  logic [cqs_pkg::CAP_W-1:0]         csr_data,
   output logic [cqs_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [cqs_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [cqs_pkg::SLOT_W-1:0]        rsp_found_slot
);
   import cqs_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CAP_RST =
      (CAP_RESET > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(CAP_RESET);

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
   endfunction

   logic [VALUE_W-1:0] mem [DEPTH];

   op_type             op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   wptr_ff, wptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]   scan_left_ff, scan_left_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_slot_ff, cmp_slot_in;
   logic               cmp_last_ff, cmp_last_in;
   status_type         res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_removed_ff, res_removed_in;
   logic [IDX_W-1:0]   res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [VALUE_W-1:0] out_removed_ff;
   logic [SLOT_W-1:0]  out_slot_ff;

   logic [31:0]        cap_raw, cap_clamp, slot_wide;
   logic               empty, full, hit, miss, issue, mem_we, rd_en;
   logic [IDX_W-1:0]   rd_addr;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= cap_ff);
   assign hit       = cmp_valid_ff && (rd_data_ff == value_ff);
   assign miss      = cmp_valid_ff && !hit && cmp_last_ff;
   assign issue     = cmd.scan_step && !hit && !miss && (scan_left_ff != '0);
   assign mem_we    = cmd.decode && (op_ff == OP_INSERT) && !full;
   assign rd_en     = (cmd.decode && (op_ff == OP_REMOVE) && !empty) || issue;
   assign rd_addr   = issue ? scan_addr_ff : head_ff;
   assign cap_raw   = 32'(csr_data);
   assign cap_clamp = (cap_raw == 32'd0) ? 32'd1 :
                      (cap_raw > DEPTH) ? 32'(DEPTH) : cap_raw;
   assign slot_wide = 32'(res_slot_ff);

   assign stat.op        = op_ff;
   assign stat.empty     = empty;
   assign stat.scan_done = hit || miss;

   always_comb begin
      cap_in         = cap_ff;
      head_in        = head_ff;
      wptr_in        = wptr_ff;
      count_in       = count_ff;
      scan_addr_in   = scan_addr_ff;
      scan_left_in   = scan_left_ff;
      cmp_valid_in   = cmp_valid_ff;
      cmp_slot_in    = cmp_slot_ff;
      cmp_last_in    = cmp_last_ff;
      res_status_in  = res_status_ff;
      res_removed_in = res_removed_ff;
      res_slot_in    = res_slot_ff;
      if (cmd.csr_write) begin
         cap_in   = cap_clamp[CNT_W-1:0];
         head_in  = '0;
         wptr_in  = '0;
         count_in = '0;
      end
      if (cmd.decode) begin
         res_status_in  = ST_OK;
         res_removed_in = '0;
         res_slot_in    = '0;
         cmp_valid_in   = 1'b0;
         case (op_ff)
            OP_INSERT: begin
               if (full) begin
                  res_status_in = ST_FULL;
               end else begin
                  wptr_in  = wrap_next(wptr_ff, cap_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (empty) res_status_in = ST_EMPTY;
            end
            OP_SEARCH: begin
               if (empty) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  scan_addr_in = head_ff;
                  scan_left_in = count_ff;
               end
            end
            default: ;
         endcase
      end
      if (cmd.remove_done) begin
         res_removed_in = rd_data_ff;
         head_in        = wrap_next(head_ff, cap_ff);
         count_in       = count_ff - CNT_W'(1);
      end
      if (cmd.scan_step) begin
         if (hit) res_slot_in = cmp_slot_ff;
         else if (miss) res_status_in = ST_NOT_FOUND;
         // Read one slot per cycle; compare it on the next.
         cmp_valid_in = issue;
         if (issue) begin
            cmp_slot_in  = scan_addr_ff;
            cmp_last_in  = (scan_left_ff == CNT_W'(1));
            scan_addr_in = wrap_next(scan_addr_ff, cap_ff);
            scan_left_in = scan_left_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wptr_ff] <= value_ff;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RST;
         head_ff      <= '0;
         wptr_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         scan_left_ff <= '0;
      end else begin
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         scan_left_ff <= scan_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_value;
      end
      scan_addr_ff   <= scan_addr_in;
      cmp_slot_ff    <= cmp_slot_in;
      cmp_last_ff    <= cmp_last_in;
      res_status_ff  <= res_status_in;
      res_removed_ff <= res_removed_in;
      res_slot_ff    <= res_slot_in;
      if (cmd.load_rsp) begin
         out_status_ff  <= res_status_ff;
         out_removed_ff <= res_removed_ff;
         out_slot_ff    <= slot_wide[SLOT_W-1:0];
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_removed_value = out_removed_ff;
   assign rsp_found_slot    = out_slot_ff;

   `CQS_NEVER(a_count_le_cap, clock, reset, count_ff > cap_ff, "entry count above capacity")
   `CQS_NEVER(a_ptr_in_ring, clock, reset, (CNT_W'(head_ff) >= cap_ff) || (CNT_W'(wptr_ff) >= cap_ff), "ring pointer beyond capacity")

endmodule

### src/cqs_controller.sv
// Controller: sequences one transaction at a time and owns the handshakes.
`include "assert_macros.svh"

module cqs_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               csr_valid,
   output logic               csr_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cqs_pkg::stat_type  stat,
   output cqs_pkg::cmd_type   cmd
);
   import cqs_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      REMOVE,
      SCAN,
      RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = (state_ff == IDLE);
   assign req_ready = (state_ff == IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.csr_write   = csr_valid && (state_ff == IDLE);
      cmd.capture     = req_valid && req_ready;
      case (state_ff)
         IDLE: begin
            if (cmd.capture) state_in = DECODE;
         end
         DECODE: begin
            cmd.decode = 1'b1;
            if (stat.op == OP_REMOVE && !stat.empty) state_in = REMOVE;
            else if (stat.op == OP_SEARCH && !stat.empty) state_in = SCAN;
            else state_in = RESPOND;
         end
         REMOVE: begin
            cmd.remove_done = 1'b1;
            state_in        = RESPOND;
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = RESPOND;
         end
         RESPOND: begin
            // Hold the result until the output register is free.
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CQS_ASSERT(a_capture_decodes, clock, reset, cmd.capture |=> state_ff == DECODE, "accepted transaction not decoded")
   `CQS_NEVER(a_no_overwrite, clock, reset, cmd.load_rsp && rsp_valid_ff && !rsp_ready, "result register overwritten")

endmodule

### src/circular_queue_with_search.sv
// Circular FIFO of signed 32-bit words with insert, remove-oldest and search by value. One
// result comes back per transaction, in order. Insert and op-code 3 go from decode straight
// to the response, remove adds one registered read of the slot memory, and search walks
// the ring through the single memory read port one slot per cycle from the oldest entry
// and stops at the first match. The result sits in an output register, so the next
// transaction is taken while it waits. A write of the capacity register (0 acts as 1,
// above DEPTH acts as DEPTH) empties the queue and is taken only while no transaction is
// in flight. There is no clearing pass after reset.
module circular_queue_with_search #(
   parameter int unsigned DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   cqs_req_if.sink   req,
   cqs_rsp_if.source rsp,
   cqs_csr_if.sink   csr
);
   import cqs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cqs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .csr_valid (csr.valid),
      .csr_ready (csr.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cqs_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req.operation),
      .req_value         (req.value),
      .csr_data          (csr.data),
      .rsp_status        (rsp.status),
      .rsp_removed_value (rsp.removed_value),
      .rsp_found_slot    (rsp.found_slot)
   );

endmodule
